// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types for the bounded deque with search: command and status codes,
// the request and response payloads and the control state encoding.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Field widths of the request and response payloads
  localparam int unsigned DataWidth = 32;
  localparam int unsigned PosWidth  = 6;
  localparam int unsigned OccWidth  = 7;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_PUSH      = 3'd1,
    CMD_POP       = 3'd2,
    CMD_READ_HEAD = 3'd3,
    CMD_SET_HEAD  = 3'd4,
    CMD_READ_NTH  = 3'd5,
    CMD_FIND      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [DataWidth-1:0]  data_value;
    logic [PosWidth-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [DataWidth-1:0]  read_value;
    logic                  found;
    logic [PosWidth-1:0]   match_position;
    logic [OccWidth-1:0]   occupancy;
    status_e               status;
  } rsp_t;

endpackage

// ----- rtl/bdq_store.sv -----
// ----------------------------------------------------------------------------
// bdq_store
// Circular element store. Both ports address the store by an offset from
// the head slot; the offset is wrapped modulo DEPTH here. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bdq_store #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned OFF_WIDTH   = 7
) (
  input  logic                       clk_i,
  input  logic [$clog2(DEPTH)-1:0]   head_i,
  input  logic                       rd_en_i,
  input  logic [OFF_WIDTH-1:0]       rd_off_i,
  input  logic                       wr_en_i,
  input  logic [OFF_WIDTH-1:0]       wr_off_i,
  input  logic [VALUE_WIDTH-1:0]     wr_data_i,
  output logic [VALUE_WIDTH-1:0]     rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = OFF_WIDTH + 1;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [SW-1:0]          rd_sum, wr_sum;
  logic [SW-1:0]          rd_wrap, wr_wrap;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] rd_data_q;

  // head + offset, one conditional subtract folds it back into range
  always_comb begin
    rd_sum  = SW'(head_i) + {1'b0, rd_off_i};
    wr_sum  = SW'(head_i) + {1'b0, wr_off_i};
    rd_wrap = (rd_sum >= SW'(DEPTH)) ? rd_sum - SW'(DEPTH) : rd_sum;
    wr_wrap = (wr_sum >= SW'(DEPTH)) ? wr_sum - SW'(DEPTH) : wr_sum;
    rd_addr = rd_wrap[AW-1:0];
    wr_addr = wr_wrap[AW-1:0];
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/bounded_deque_with_search_core.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Flow: accepting a request in the idle state issues the store read; the
//   execute state then writes the store where the command needs it, updates
//   the pointers and registers the response. Find stays in execute, comparing
//   the entries after the head one at a time. No new request is taken until
//   the last one leaves execute; a response held by the receiver stalls it.
// Reset: head pointer, count and response valid clear at once; the element
//   store is not cleared and holds no valid data until written.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::rsp_t out_rsp_o
);

  import bdq_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned OFFW = (CW > PosWidth) ? CW : PosWidth;
  localparam int unsigned EW   = (CW > OccWidth) ? CW : OccWidth;
  localparam int unsigned XW   = (VALUE_WIDTH > DataWidth) ? VALUE_WIDTH : DataWidth;

  state_e                 state_q, state_d;
  req_t                   req_q;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   out_valid_q;
  rsp_t                   out_rsp_q, rsp;

  logic                   accept, out_free, done, commit;
  logic                   rd_en, wr_en;
  logic [OFFW-1:0]        rd_off, wr_off;
  logic [VALUE_WIDTH-1:0] rd_data, val;
  logic [XW-1:0]          val_ext, rd_ext;
  logic [OFFW-1:0]        idx_ext;
  logic [EW-1:0]          occ_ext;
  logic                   empty, full, match;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == ST_EXEC) && done && out_free;

  // Operand value cut to the stored width
  assign val_ext = XW'(req_q.data_value);
  assign val     = val_ext[VALUE_WIDTH-1:0];
  assign rd_ext  = XW'(rd_data);
  assign idx_ext = OFFW'(idx_q);
  assign occ_ext = EW'(count_d);

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));
  assign match = (rd_data == val);

  bdq_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .OFF_WIDTH   (OFFW)
  ) u_store (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .rd_en_i   (rd_en),
    .rd_off_i  (rd_off),
    .wr_en_i   (wr_en),
    .wr_off_i  (wr_off),
    .wr_data_i (val),
    .rd_data_o (rd_data)
  );

  // Control state and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, walk index and response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    idx_q <= idx_d;
    if (commit) begin
      out_rsp_q <= rsp;
    end
  end

  // Next state, store access and response
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    rd_off  = '0;
    wr_en   = 1'b0;
    wr_off  = '0;
    done    = 1'b1;
    rsp     = '0;

    unique case (state_q)
      ST_IDLE: begin
        // Read the head, or the requested slot, while the request lands
        if (accept) begin
          rd_en   = 1'b1;
          rd_off  = (in_req_i.cmd == CMD_READ_NTH) ? OFFW'(in_req_i.position) : '0;
          idx_d   = '0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_q.cmd)
          CMD_APPEND: begin
            if (full) begin
              rsp.status = STAT_FULL;
            end else begin
              wr_en   = commit;
              wr_off  = OFFW'(count_q);
              count_d = count_q + 1'b1;
            end
          end
          CMD_PUSH: begin
            if (full) begin
              rsp.status = STAT_FULL;
            end else begin
              wr_en   = commit;
              wr_off  = OFFW'(DEPTH - 1);
              head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CMD_POP: begin
            if (empty) begin
              rsp.status = STAT_EMPTY;
            end else begin
              rsp.read_value = rd_ext[DataWidth-1:0];
              head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
              count_d = count_q - 1'b1;
            end
          end
          CMD_READ_HEAD: begin
            if (empty) begin
              rsp.status = STAT_EMPTY;
            end else begin
              rsp.read_value = rd_ext[DataWidth-1:0];
            end
          end
          CMD_SET_HEAD: begin
            if (empty) begin
              rsp.status = STAT_EMPTY;
            end else begin
              wr_en = commit;
            end
          end
          CMD_READ_NTH: begin
            if (OFFW'(req_q.position) >= OFFW'(count_q)) begin
              rsp.status = STAT_RANGE;
            end else begin
              rsp.read_value = rd_ext[DataWidth-1:0];
            end
          end
          CMD_FIND: begin
            // Compare one entry per cycle, stop on match or at the tail
            done = empty || match || (idx_q + 1'b1 == count_q);
            rsp.found          = !empty && match;
            rsp.match_position = (!empty && match) ? idx_ext[PosWidth-1:0] : '0;
            if (!done) begin
              rd_en  = 1'b1;
              rd_off = idx_ext + 1'b1;
              idx_d  = idx_q + 1'b1;
            end
          end
          CMD_CLEAR: begin
            head_d  = '0;
            count_d = '0;
          end
          default: begin
          end
        endcase
        rsp.occupancy = occ_ext[OccWidth-1:0];
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Count stays within the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  // Head pointer stays a valid slot
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= AW'(DEPTH - 1))
    else $error("head pointer out of range");

  // Store never reads and writes in the same cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("store read and write overlap");

  // A successful pop drops the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && req_q.cmd == CMD_POP && !empty) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not decrement count");

endmodule
